/* hdl/jspd_pkg.sv */
// Shared constants, types and helper function of the joystick stepper phase driver.
`timescale 1ns / 1ps
package jspd_pkg;

	localparam int SEQUENCE_STEPS = 8;
	localparam int PHASE_W        = $clog2(SEQUENCE_STEPS);
	localparam int MOTOR_COUNT    = 3;
	localparam int AXIS_W         = 8;
	localparam int BYTE_W         = 8;
	localparam int PHASE_OUT_W    = 3;
	localparam int DEAD_W         = 7;
	localparam int SELECT_W       = 3;
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 8;
	localparam int IN_DATA_W      = 24;
	localparam int OUT_FIELDS_W   = 2 * BYTE_W + MOTOR_COUNT * PHASE_OUT_W;
	localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_DATA_W - OUT_FIELDS_W;

	localparam logic [AXIS_W-1:0]   CENTER_RESET = 8'd127;
	localparam logic [DEAD_W-1:0]   DEAD_RESET   = 7'd15;
	localparam logic [BYTE_W-1:0]   MASK_HIGH    = 8'b1111_0000;
	localparam logic [BYTE_W-1:0]   MASK_LOW     = 8'b0000_1111;
	localparam logic [SELECT_W-1:0] SELECT_RESET = 3'd4;

	localparam logic [PHASE_W-1:0] STEP_LAST = PHASE_W'(SEQUENCE_STEPS - 1);

	// half-step coil patterns, one nibble per motor lane
	localparam logic [BYTE_W-1:0] HALF_STEP [8] = '{
		8'b1000_1000, 8'b1100_1100, 8'b0100_0100, 8'b0110_0110,
		8'b0010_0010, 8'b0011_0011, 8'b0001_0001, 8'b1001_1001
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CENTER_LEVEL    = 3'd0,
		REG_DEAD_WIDTH      = 3'd1,
		REG_BASE_LANE_MASK  = 3'd2,
		REG_LOWER_LANE_MASK = 3'd3,
		REG_UPPER_LANE_MASK = 3'd4,
		REG_EXPANDER_SELECT = 3'd5
	} cfg_reg_t;

	// low three bits of a phase index, zero filled for short indexes
	function automatic logic [PHASE_OUT_W-1:0] phase_low3(logic [PHASE_W-1:0] p);
		logic [PHASE_W+PHASE_OUT_W-1:0] w;
		w = {{PHASE_OUT_W{1'b0}}, p};
		return w[PHASE_OUT_W-1:0];
	endfunction

endpackage

/* hdl/joystick_stepper_phase_driver.sv */
// Top level: joystick axis words in, stepper coil bytes and phase indexes out.
`timescale 1ns / 1ps
// Joystick stepper phase driver. Each input word carries three 8-bit axis samples
// (base, lower arm, upper arm). A sample above center_level + dead_width steps that
// motor's phase forward, one below center_level - dead_width steps it back, anything
// else holds. Each phase picks a half-step coil pattern that is masked to the motor's
// lanes and ORed into the byte of the expander selected for it. A word is taken every
// cycle unless a stalled result holds the input register; the accepting edge loads the
// input register, which passes the word into the result register once that is free or
// read, and the output register lets a new word enter while a result waits.
// Configuration writes are taken at any time with cfg_ready held high and are meant to
// be issued only while no word is in flight; indexes 6 and 7 are ignored.
module joystick_stepper_phase_driver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// base_axis[7:0], lower_axis[15:8], upper_axis[23:16]
	input  logic [jspd_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// first_expander_byte[7:0], second_expander_byte[15:8], base_phase[18:16],
	// lower_phase[21:19], upper_phase[24:22], zero fill above
	output logic [jspd_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jspd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [jspd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [jspd_pkg::AXIS_W-1:0]   center_q;
	logic [jspd_pkg::DEAD_W-1:0]   dead_q;
	logic [jspd_pkg::BYTE_W-1:0]   lane_mask_q [jspd_pkg::MOTOR_COUNT];
	logic [jspd_pkg::SELECT_W-1:0] select_q;
	logic [jspd_pkg::PHASE_W-1:0]  phase_q [jspd_pkg::MOTOR_COUNT];

	logic                          valid_s1;
	logic [jspd_pkg::AXIS_W-1:0]   axis_s1 [jspd_pkg::MOTOR_COUNT];

	logic                          out_valid_q;
	logic [jspd_pkg::BYTE_W-1:0]   first_q;
	logic [jspd_pkg::BYTE_W-1:0]   second_q;
	logic [jspd_pkg::PHASE_OUT_W-1:0] phase_out_q [jspd_pkg::MOTOR_COUNT];

	logic                          advance;
	logic [jspd_pkg::AXIS_W:0]     hi_bound;
	logic [jspd_pkg::AXIS_W+1:0]   lo_bound;
	logic [jspd_pkg::PHASE_W-1:0]  phase_next [jspd_pkg::MOTOR_COUNT];
	logic [jspd_pkg::BYTE_W-1:0]   first_next;
	logic [jspd_pkg::BYTE_W-1:0]   second_next;
	logic [jspd_pkg::BYTE_W-1:0]   bits;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{jspd_pkg::OUT_PAD_W{1'b0}}, phase_out_q[2], phase_out_q[1],
		phase_out_q[0], second_q, first_q};

	// bounds at extra width: hi may pass 255, lo may go negative (sign in top bit)
	assign hi_bound = {1'b0, center_q} + {2'b00, dead_q};
	assign lo_bound = {2'b00, center_q} - {3'b000, dead_q};

	always_comb begin
		first_next  = '0;
		second_next = '0;
		bits        = '0;
		for (int m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
			phase_next[m] = phase_q[m];
			if ({1'b0, axis_s1[m]} > hi_bound) begin
				phase_next[m] = (phase_q[m] == jspd_pkg::STEP_LAST) ? '0 : phase_q[m] + 1'b1;
			end else if (!lo_bound[jspd_pkg::AXIS_W+1] && ({2'b00, axis_s1[m]} < lo_bound)) begin
				phase_next[m] = (phase_q[m] == '0) ? jspd_pkg::STEP_LAST : phase_q[m] - 1'b1;
			end
			bits = lane_mask_q[m] & jspd_pkg::HALF_STEP[jspd_pkg::phase_low3(phase_next[m])];
			if (select_q[m]) begin
				second_next = second_next | bits;
			end else begin
				first_next = first_next | bits;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q       <= jspd_pkg::CENTER_RESET;
			dead_q         <= jspd_pkg::DEAD_RESET;
			lane_mask_q[0] <= jspd_pkg::MASK_HIGH;
			lane_mask_q[1] <= jspd_pkg::MASK_LOW;
			lane_mask_q[2] <= jspd_pkg::MASK_HIGH;
			select_q       <= jspd_pkg::SELECT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jspd_pkg::REG_CENTER_LEVEL:    center_q       <= cfg_data;
				jspd_pkg::REG_DEAD_WIDTH:      dead_q         <= cfg_data[jspd_pkg::DEAD_W-1:0];
				jspd_pkg::REG_BASE_LANE_MASK:  lane_mask_q[0] <= cfg_data;
				jspd_pkg::REG_LOWER_LANE_MASK: lane_mask_q[1] <= cfg_data;
				jspd_pkg::REG_UPPER_LANE_MASK: lane_mask_q[2] <= cfg_data;
				jspd_pkg::REG_EXPANDER_SELECT: select_q       <= cfg_data[jspd_pkg::SELECT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
				phase_q[m] <= jspd_pkg::PHASE_W'(m);
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				for (int m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
					phase_q[m] <= phase_next[m];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			for (int m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
				axis_s1[m] <= s_tdata[m*jspd_pkg::AXIS_W +: jspd_pkg::AXIS_W];
			end
		end
		if (advance) begin
			first_q  <= first_next;
			second_q <= second_next;
			for (int m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
				phase_out_q[m] <= jspd_pkg::phase_low3(phase_next[m]);
			end
		end
	end

endmodule

/* hdl/jspd_checker.sv */
// Port-level checker for the joystick stepper phase driver and its bind.
`timescale 1ns / 1ps
module jspd_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [jspd_pkg::OUT_DATA_W-1:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed or dropped while stalled");

	// fill bits above the phase fields stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[jspd_pkg::OUT_DATA_W-1:jspd_pkg::OUT_FIELDS_W] == '0)
		else $error("fill bits of result word not zero");

	// with the result register empty the input side never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while result register empty");

	// an empty result register with no word taken, still empty after, leaves nothing to present
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) ##1 !m_tvalid |=> !m_tvalid)
		else $error("result word appeared with no word accepted");

endmodule

bind joystick_stepper_phase_driver jspd_port_checker u_jspd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/sv/jspd_checker.sv */
// Checker: predicts coil bytes and phases from accepted axis words and compares them.
`timescale 1ns / 1ps
module jspd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// base_axis[7:0], lower_axis[15:8], upper_axis[23:16]
	input  logic [jspd_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// first_expander_byte[7:0], second_expander_byte[15:8], base_phase[18:16],
	// lower_phase[21:19], upper_phase[24:22], zero fill above
	input  logic [jspd_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [jspd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [jspd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                pending_count,
	output int                                checked_count
);

	typedef struct packed {
		logic [jspd_pkg::BYTE_W-1:0]      first_byte;
		logic [jspd_pkg::BYTE_W-1:0]      second_byte;
		logic [jspd_pkg::PHASE_OUT_W-1:0] base_phase;
		logic [jspd_pkg::PHASE_OUT_W-1:0] lower_phase;
		logic [jspd_pkg::PHASE_OUT_W-1:0] upper_phase;
	} coil_word_t;

	coil_word_t                    expected_coils [$];
	logic [jspd_pkg::AXIS_W-1:0]   center = 8'd127;
	logic [jspd_pkg::DEAD_W-1:0]   dead = 7'd15;
	logic [jspd_pkg::BYTE_W-1:0]   lane_mask [jspd_pkg::MOTOR_COUNT];
	logic [jspd_pkg::SELECT_W-1:0] on_second = 3'b100;
	logic [jspd_pkg::PHASE_W-1:0]  phase [jspd_pkg::MOTOR_COUNT];
	int                            errs = 0;
	int                            checked = 0;

	function automatic logic [jspd_pkg::BYTE_W-1:0] coil_pattern(input int step);
		case (step)
			0: return 8'b1000_1000;
			1: return 8'b1100_1100;
			2: return 8'b0100_0100;
			3: return 8'b0110_0110;
			4: return 8'b0010_0010;
			5: return 8'b0011_0011;
			6: return 8'b0001_0001;
			default: return 8'b1001_1001;
		endcase
	endfunction

	// bounds are plain ints, so one past the byte range simply never fires
	function automatic int step_phase(input int p, input int sample, input int lo, input int hi);
		if (sample > hi)
			return (p + 1) % jspd_pkg::SEQUENCE_STEPS;
		if (sample < lo)
			return (p + jspd_pkg::SEQUENCE_STEPS - 1) % jspd_pkg::SEQUENCE_STEPS;
		return p;
	endfunction

	task automatic advance_motors(input logic [jspd_pkg::IN_DATA_W-1:0] axes);
		int hi;
		int lo;
		int p;
		int m;
		logic [jspd_pkg::BYTE_W-1:0] bits;
		coil_word_t w;
		hi = int'(center) + int'(dead);
		lo = int'(center) - int'(dead);
		w = '0;
		for (m = 0; m < jspd_pkg::MOTOR_COUNT; m++) begin
			p = step_phase(int'(phase[m]),
				int'(axes[jspd_pkg::AXIS_W*m +: jspd_pkg::AXIS_W]), lo, hi);
			phase[m] = jspd_pkg::PHASE_W'(p);
			bits = lane_mask[m] & coil_pattern(p & 7);
			if (on_second[m])
				w.second_byte = w.second_byte | bits;
			else
				w.first_byte = w.first_byte | bits;
		end
		w.base_phase  = jspd_pkg::PHASE_OUT_W'(int'(phase[0]) & 7);
		w.lower_phase = jspd_pkg::PHASE_OUT_W'(int'(phase[1]) & 7);
		w.upper_phase = jspd_pkg::PHASE_OUT_W'(int'(phase[2]) & 7);
		expected_coils.push_back(w);
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	task automatic check_word(input logic [jspd_pkg::OUT_DATA_W-1:0] word);
		coil_word_t want;
		if (expected_coils.size() == 0) begin
			errs++;
			$display("%0t: result word %h arrived with nothing expected, expected none, actual %h",
				$time, word, word);
		end else begin
			want = expected_coils.pop_front();
			checked++;
			compare_field("first_expander_byte", 32'(want.first_byte),
				32'(word[jspd_pkg::BYTE_W-1:0]));
			compare_field("second_expander_byte", 32'(want.second_byte),
				32'(word[2*jspd_pkg::BYTE_W-1:jspd_pkg::BYTE_W]));
			compare_field("base_phase", 32'(want.base_phase),
				32'(word[2*jspd_pkg::BYTE_W +: jspd_pkg::PHASE_OUT_W]));
			compare_field("lower_phase", 32'(want.lower_phase),
				32'(word[2*jspd_pkg::BYTE_W+jspd_pkg::PHASE_OUT_W +: jspd_pkg::PHASE_OUT_W]));
			compare_field("upper_phase", 32'(want.upper_phase),
				32'(word[2*jspd_pkg::BYTE_W+2*jspd_pkg::PHASE_OUT_W +: jspd_pkg::PHASE_OUT_W]));
			compare_field("zero fill", 32'(0),
				32'(word[jspd_pkg::OUT_DATA_W-1 -: jspd_pkg::OUT_PAD_W]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center = 8'd127;
			dead = 7'd15;
			lane_mask[0] = 8'hF0;
			lane_mask[1] = 8'h0F;
			lane_mask[2] = 8'hF0;
			on_second = 3'b100;
			phase[0] = jspd_pkg::PHASE_W'(0);
			phase[1] = jspd_pkg::PHASE_W'(1);
			phase[2] = jspd_pkg::PHASE_W'(2);
			expected_coils.delete();
			errs = 0;
			checked = 0;
			fail_count <= 0;
			pending_count <= 0;
			checked_count <= 0;
		end else begin
			// retire the oldest expectation before queueing a new one
			if (m_tvalid && m_tready)
				check_word(m_tdata);
			if (s_tvalid && s_tready)
				advance_motors(s_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					jspd_pkg::REG_CENTER_LEVEL:    center = cfg_data;
					jspd_pkg::REG_DEAD_WIDTH:      dead = cfg_data[jspd_pkg::DEAD_W-1:0];
					jspd_pkg::REG_BASE_LANE_MASK:  lane_mask[0] = cfg_data;
					jspd_pkg::REG_LOWER_LANE_MASK: lane_mask[1] = cfg_data;
					jspd_pkg::REG_UPPER_LANE_MASK: lane_mask[2] = cfg_data;
					jspd_pkg::REG_EXPANDER_SELECT: on_second = cfg_data[jspd_pkg::SELECT_W-1:0];
					default: ;  // drop writes to unused indexes
				endcase
			end
			fail_count <= errs;
			pending_count <= expected_coils.size();
			checked_count <= checked;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, axis and register stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
	import jspd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_WORDS = 54;
	localparam int PHASE_COUNT = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     fail_count;
	int                     pending_count;
	int                     checked_count;
	int                     rx_stall_pct = 0;
	int                     hold_wanted = 0;
	int                     tx_idle_pct = 0;
	int                     cycle_count = 0;
	int                     words_sent = 0;
	logic [AXIS_W-1:0]      cur_center = 8'd127;
	logic [DEAD_W-1:0]      cur_dead = 7'd15;

	joystick_stepper_phase_driver i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	jspd_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.checked_count(checked_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin : rx_side
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_wanted != served) begin
				served = hold_wanted;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_word(input logic [IN_DATA_W-1:0] axes);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= axes;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic send_axes(input int base, input int lower, input int upper);
		send_word({8'(upper), 8'(lower), 8'(base)});
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	// lean on the band edges, the center and the byte ends
	function automatic logic [AXIS_W-1:0] pick_axis();
		int c;
		c = int'(cur_center);
		case ($urandom_range(0, 9))
			0: c = c + int'(cur_dead) + int'($urandom_range(0, 1));
			1: c = c - int'(cur_dead) - int'($urandom_range(0, 1));
			2: ;
			3: c = int'($urandom_range(0, 1)) * 255;
			default: c = int'($urandom_range(0, 255));
		endcase
		if (c < 0 || c > 255)
			c = int'($urandom_range(0, 255));
		return 8'(c);
	endfunction

	initial begin : stimulus
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] mb;
		logic [7:0] ml;
		logic [7:0] mu;
		logic [7:0] sel;
		int ph;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: byte ends, band edges, and wrap in both directions
		send_axes(0, 255, 127);
		send_axes(255, 0, 127);
		send_axes(142, 143, 112);
		send_axes(111, 112, 143);
		send_axes(127, 113, 141);
		send_axes(128, 126, 0);
		repeat (7) send_axes(255, 255, 0);
		repeat (7) send_axes(0, 0, 255);
		s_tvalid <= 1'b0;

		for (ph = 1; ph <= PHASE_COUNT; ph++) begin
			case (ph)
				1: begin c = 8'd0;   d = 8'd0;   mb = 8'hFF; ml = 8'hFF; mu = 8'hFF; sel = 8'h00; end
				2: begin c = 8'd255; d = 8'hFF;  mb = 8'h00; ml = 8'h00; mu = 8'h00; sel = 8'hFF; end
				3: begin c = 8'd0;   d = 8'd127; mb = 8'h0F; ml = 8'hF0; mu = 8'h3C; sel = 8'h01; end
				4: begin c = 8'd255; d = 8'd0;   mb = 8'hA5; ml = 8'h5A; mu = 8'hFF; sel = 8'h02; end
				5: begin c = 8'd128; d = 8'd1;   mb = 8'hC3; ml = 8'h3C; mu = 8'h96; sel = 8'h05; end
				default: begin
					c = 8'($urandom_range(0, 255));
					d = 8'($urandom_range(0, 255));
					mb = 8'($urandom_range(0, 255));
					ml = 8'($urandom_range(0, 255));
					mu = 8'($urandom_range(0, 255));
					sel = 8'($urandom_range(0, 255));
				end
			endcase
			wait_drained();
			write_reg(REG_CENTER_LEVEL, c);
			write_reg(REG_DEAD_WIDTH, d);
			write_reg(REG_BASE_LANE_MASK, mb);
			write_reg(REG_LOWER_LANE_MASK, ml);
			write_reg(REG_UPPER_LANE_MASK, mu);
			write_reg(REG_EXPANDER_SELECT, sel);
			write_reg((ph % 2) ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom_range(0, 255)));
			cfg_valid <= 1'b0;
			cur_center = c;
			cur_dead = d[DEAD_W-1:0];

			case ((ph - 1) % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct = 61; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct <= 61; end
				default: begin tx_idle_pct = 16; rx_stall_pct <= 16; end
			endcase

			for (n = 0; n < PHASE_WORDS; n++) begin
				// long receiver hold-off while words keep coming: fill the block
				if (ph == 1 && n == 4)
					hold_wanted <= hold_wanted + 1;
				send_word({pick_axis(), pick_axis(), pick_axis()});
			end
			s_tvalid <= 1'b0;
		end

		wait_drained();
		$display("tb_top: %0d axis words sent, %0d result words checked",
			words_sent, checked_count);
		$display("tb_top: reset values plus %0d register sets incl. range ends, gaps, stalls",
			PHASE_COUNT);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/jspd_pkg.sv
hdl/joystick_stepper_phase_driver.sv
hdl/jspd_checker.sv
tb/sv/jspd_checker.sv
tb/sv/tb_top.sv
